>>> rtl/life_grid_generation_engine_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Life grid engine
// Clocked property checks with a synchronous active-low reset as disable.
// ---------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_CORE_ASSERT_SVH
`define LIFE_GRID_GENERATION_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTH
// check a property on every rising edge outside reset
`define LGE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
// check that a condition never holds outside reset
`define LGE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `LGE_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define LGE_ASSERT(label, clk, rst_n, prop, msg)
`define LGE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/lge_pkg.sv
// ---------------------------------------------------------------------------
// Life grid engine package
// Shared constants, operation codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lge_pkg;

    // default grid bounds
    localparam int MAX_LINES_DEF          = 64;
    localparam int MAX_CELLS_PER_LINE_DEF = 64;

    // field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 6;
    localparam int GEN_W      = 16;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_LINE = 1'd1;

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] LINES_IN_USE_RST   = 7'd50;
    localparam logic [CFG_DATA_W-1:0] CELLS_PER_LINE_RST = 7'd60;

    // B3/S23 neighbour counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;    // take the item, issue the first row read
        logic access;     // finish a cell write or read, emit result
        logic load0;      // load line 0 into the scan window
        logic loadn;      // load the line below into the scan window
        logic scan_step;  // evaluate one cell and rotate the window
        logic row_write;  // store the new line, step down one line
        logic finish;     // count the generation, emit result
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic grid_empty;
        logic last_pos;
        logic last_row;
    } t_ctrl_status;

endpackage

>>> rtl/life_grid_generation_engine_core.sv
// ---------------------------------------------------------------------------
// Life grid generation engine core
// Conway's Life (B3/S23) grid with cell write, cell read and advance items.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows on o_result_strobe for a single cycle, and it cannot be held off.
// A cell write or read keeps busy high for its access state only. An advance
// holds busy through the load, scan and write states of each used line and
// the finish state (just the finish state on an empty grid); the scan window
// rotates through every position of the full-width line one cell per clock.
// Each result appears in the cycle in which busy falls. Lines never written
// read as dead, so the grid RAM needs no clearing pass after reset.
// Configuration is to be written only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module life_grid_generation_engine_core #(
    parameter int MAX_LINES          = lge_pkg::MAX_LINES_DEF,
    parameter int MAX_CELLS_PER_LINE = lge_pkg::MAX_CELLS_PER_LINE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lge_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lge_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [lge_pkg::OP_W-1:0]       i_operation,
    input  logic [lge_pkg::COORD_W-1:0]    i_line,
    input  logic [lge_pkg::COORD_W-1:0]    i_position,
    input  logic                           i_cell_value,
    output logic                           o_result_strobe,
    output logic                           o_read_value,
    output logic                           o_out_of_range,
    output logic [lge_pkg::GEN_W-1:0]      o_generation_count
);

    lge_pkg::t_ctrl_cmd    w_cmd;
    lge_pkg::t_ctrl_status w_status;

    // sequencer
    lge_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .busy        (busy)
    );

    // grid storage and scan
    lge_datapath #(
        .MAX_LINES          (MAX_LINES),
        .MAX_CELLS_PER_LINE (MAX_CELLS_PER_LINE)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_operation        (i_operation),
        .i_line             (i_line),
        .i_position         (i_position),
        .i_cell_value       (i_cell_value),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_result_strobe    (o_result_strobe),
        .o_read_value       (o_read_value),
        .o_out_of_range     (o_out_of_range),
        .o_generation_count (o_generation_count)
    );

endmodule

>>> rtl/lge_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module lge_ram #(
    parameter int   WIDTH = 1,
    parameter int   DEPTH = 2,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> rtl/lge_datapath.sv
// ---------------------------------------------------------------------------
// Life grid engine datapath
// Line-wide grid RAM with line valid bits, rotating three-line scan window,
// neighbour count, configuration registers and result registers.
// ---------------------------------------------------------------------------
`include "life_grid_generation_engine_core_assert.svh"

module lge_datapath #(
    parameter int MAX_LINES          = lge_pkg::MAX_LINES_DEF,
    parameter int MAX_CELLS_PER_LINE = lge_pkg::MAX_CELLS_PER_LINE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [lge_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lge_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [lge_pkg::OP_W-1:0]         i_operation,
    input  logic [lge_pkg::COORD_W-1:0]      i_line,
    input  logic [lge_pkg::COORD_W-1:0]      i_position,
    input  logic                             i_cell_value,
    input  lge_pkg::t_ctrl_cmd               i_cmd,
    output lge_pkg::t_ctrl_status            o_status,
    output logic                             o_result_strobe,
    output logic                             o_read_value,
    output logic                             o_out_of_range,
    output logic [lge_pkg::GEN_W-1:0]        o_generation_count
);

    localparam int LW  = $clog2(MAX_LINES);
    localparam int PW  = $clog2(MAX_CELLS_PER_LINE);
    localparam int LCW = LW + 1;
    localparam int PCW = PW + 1;
    localparam int C   = MAX_CELLS_PER_LINE - 1;
    localparam int VD  = 1 << LW;

    // configuration
    logic [lge_pkg::CFG_DATA_W-1:0] r_lines_in_use;
    logic [lge_pkg::CFG_DATA_W-1:0] r_cells_per_line;
    logic [LCW-1:0]                 w_used_lines;
    logic [PCW-1:0]                 w_used_cells;

    // item
    logic [lge_pkg::OP_W-1:0]    r_op;
    logic [lge_pkg::COORD_W-1:0] r_line;
    logic [lge_pkg::COORD_W-1:0] r_pos;
    logic                        r_val;
    logic                        r_oor;
    logic                        w_inside;
    logic                        w_cell_op;

    // grid RAM
    logic [VD-1:0]                 r_row_valid;
    logic                          r_rd_valid;
    logic                          w_rd_en;
    logic [LW-1:0]                 w_rd_addr;
    logic                          w_wr_en;
    logic [LW-1:0]                 w_wr_addr;
    logic [MAX_CELLS_PER_LINE-1:0] w_wr_data;
    logic [MAX_CELLS_PER_LINE-1:0] w_ram_q;
    logic [MAX_CELLS_PER_LINE-1:0] w_rd_row;
    logic [MAX_CELLS_PER_LINE-1:0] w_mod_row;
    logic                          w_cell_bit;

    // scan window
    logic [MAX_CELLS_PER_LINE-1:0] r_prev;
    logic [MAX_CELLS_PER_LINE-1:0] r_cur;
    logic [MAX_CELLS_PER_LINE-1:0] r_next;
    logic [MAX_CELLS_PER_LINE-1:0] r_new_row;
    logic [LW-1:0]                 r_scan_line;
    logic [PW-1:0]                 r_scan_pos;
    logic                          w_left_ok;
    logic                          w_right_ok;
    logic                          w_prev_ok;
    logic                          w_in_row;
    logic                          w_next_exists;
    logic [3:0]                    w_count;
    logic                          w_new_bit;

    // results
    logic [lge_pkg::GEN_W-1:0] r_generations;
    logic [lge_pkg::GEN_W-1:0] n_generations;
    logic                      r_strobe;
    logic                      r_read_value;
    logic                      r_out_of_range;
    logic [lge_pkg::GEN_W-1:0] r_gen_out;

    // saturate the used grid size at the maximum
    assign w_used_lines = (32'(r_lines_in_use) > 32'(MAX_LINES)) ?
                          LCW'(MAX_LINES) : LCW'(r_lines_in_use);
    assign w_used_cells = (32'(r_cells_per_line) > 32'(MAX_CELLS_PER_LINE)) ?
                          PCW'(MAX_CELLS_PER_LINE) : PCW'(r_cells_per_line);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines_in_use   <= lge_pkg::LINES_IN_USE_RST;
            r_cells_per_line <= lge_pkg::CELLS_PER_LINE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lge_pkg::CFG_LINES_IN_USE:   r_lines_in_use   <= i_cfg_wdata;
                lge_pkg::CFG_CELLS_PER_LINE: r_cells_per_line <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // range check of the incoming coordinates
    assign w_inside  = (32'(i_line) < 32'(w_used_lines)) &&
                       (32'(i_position) < 32'(w_used_cells));
    assign w_cell_op = (i_operation == lge_pkg::OP_WRITE) ||
                       (i_operation == lge_pkg::OP_READ);

    // hold the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_line <= i_line;
            r_pos  <= i_position;
            r_val  <= i_cell_value;
            r_oor  <= w_cell_op && !w_inside;
        end
    end

    // select the RAM read address
    assign w_rd_en = i_cmd.capture || i_cmd.load0 || i_cmd.row_write;
    always_comb begin
        w_rd_addr = LW'(32'(r_scan_line) + 2);
        if (i_cmd.capture) begin
            w_rd_addr = (i_operation == lge_pkg::OP_ADVANCE) ? '0 : LW'(i_line);
        end else if (i_cmd.load0) begin
            w_rd_addr = LW'(1);
        end
    end

    // a line never written reads as all dead
    assign w_rd_row   = r_rd_valid ? w_ram_q : '0;
    assign w_cell_bit = w_rd_row[PW'(r_pos)];

    always_comb begin
        w_mod_row              = w_rd_row;
        w_mod_row[PW'(r_pos)]  = r_val;
    end

    // select the RAM write
    assign w_wr_en   = i_cmd.row_write ||
                       (i_cmd.access && (r_op == lge_pkg::OP_WRITE) && !r_oor);
    assign w_wr_addr = i_cmd.access ? LW'(r_line) : r_scan_line;
    assign w_wr_data = i_cmd.access ? w_mod_row : r_new_row;

    lge_ram #(
        .WIDTH (MAX_CELLS_PER_LINE),
        .DEPTH (MAX_LINES)
    ) u_grid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_q)
    );

    // track which lines hold written data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (w_wr_en) begin
            r_row_valid[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_valid <= r_row_valid[w_rd_addr];
        end
    end

    // neighbour qualifiers at the current scan position
    assign w_left_ok     = (r_scan_pos != '0);
    assign w_right_ok    = (32'(r_scan_pos) + 1) < 32'(w_used_cells);
    assign w_prev_ok     = (r_scan_line != '0);
    assign w_in_row      = 32'(r_scan_pos) < 32'(w_used_cells);
    assign w_next_exists = (32'(r_scan_line) + 1) < 32'(w_used_lines);

    // count live neighbours: left taps sit at the top after rotation
    assign w_count = 4'(w_left_ok & r_cur[C]) + 4'(w_right_ok & r_cur[1])
                   + 4'(w_prev_ok & w_left_ok & r_prev[C])
                   + 4'(w_prev_ok & r_prev[0])
                   + 4'(w_prev_ok & w_right_ok & r_prev[1])
                   + 4'(w_left_ok & r_next[C]) + 4'(r_next[0])
                   + 4'(w_right_ok & r_next[1]);

    assign w_new_bit = (w_count == lge_pkg::BIRTH_COUNT) ||
                       ((w_count == lge_pkg::SURVIVE_COUNT) && r_cur[0]);

    // load, rotate and advance the scan window
    always_ff @(posedge i_clk) begin
        if (i_cmd.load0) begin
            r_cur     <= w_rd_row;
            r_new_row <= w_rd_row;
        end else if (i_cmd.scan_step) begin
            r_prev    <= {r_prev[0], r_prev[C:1]};
            r_cur     <= {r_cur[0], r_cur[C:1]};
            r_next    <= {r_next[0], r_next[C:1]};
            r_new_row <= {(w_in_row ? w_new_bit : r_new_row[0]), r_new_row[C:1]};
        end else if (i_cmd.row_write) begin
            r_prev    <= r_cur;
            r_cur     <= r_next;
            r_new_row <= r_next;
        end else if (i_cmd.loadn) begin
            r_next    <= w_next_exists ? w_rd_row : '0;
        end
    end

    // scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_line <= '0;
            r_scan_pos  <= '0;
        end else if (i_cmd.load0) begin
            r_scan_line <= '0;
        end else if (i_cmd.loadn) begin
            r_scan_pos  <= '0;
        end else if (i_cmd.scan_step && !o_status.last_pos) begin
            r_scan_pos  <= PW'(32'(r_scan_pos) + 1);
        end else if (i_cmd.row_write && !o_status.last_row) begin
            r_scan_line <= LW'(32'(r_scan_line) + 1);
        end
    end

    assign o_status.grid_empty = (w_used_lines == '0) || (w_used_cells == '0);
    assign o_status.last_pos   = (r_scan_pos == PW'(MAX_CELLS_PER_LINE - 1));
    assign o_status.last_row   = !w_next_exists;

    // generation counter and result registers
    assign n_generations = r_generations + lge_pkg::GEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_generations  <= '0;
            r_strobe       <= 1'b0;
            r_read_value   <= 1'b0;
            r_out_of_range <= 1'b0;
            r_gen_out      <= '0;
        end else begin
            r_strobe <= i_cmd.access || i_cmd.finish;
            if (i_cmd.finish) begin
                r_generations <= n_generations;
            end
            if (i_cmd.access || i_cmd.finish) begin
                r_read_value   <= i_cmd.access && (r_op == lge_pkg::OP_READ) &&
                                  !r_oor && w_cell_bit;
                r_out_of_range <= i_cmd.access && r_oor;
                r_gen_out      <= i_cmd.finish ? n_generations : r_generations;
            end
        end
    end

    assign o_result_strobe    = r_strobe;
    assign o_read_value       = r_read_value;
    assign o_out_of_range     = r_out_of_range;
    assign o_generation_count = r_gen_out;

    // checks
    `LGE_ASSERT(a_strobe_source, i_clk, i_rst_n, r_strobe |-> $past(i_cmd.access || i_cmd.finish), "result strobe without access or finish")
    `LGE_ASSERT(a_gen_step, i_clk, i_rst_n, i_cmd.finish |=> (r_generations == $past(n_generations)), "generation count did not step")
    `LGE_ASSERT_NEVER(a_oor_read, i_clk, i_rst_n, r_strobe && r_out_of_range && r_read_value, "read value on out of range item")

endmodule

>>> rtl/lge_ctrl.sv
// ---------------------------------------------------------------------------
// Life grid engine controller
// Sequences cell accesses and the line-by-line generation scan.
// ---------------------------------------------------------------------------
`include "life_grid_generation_engine_core_assert.svh"

module lge_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [lge_pkg::OP_W-1:0] i_operation,
    input  lge_pkg::t_ctrl_status    i_status,
    output lge_pkg::t_ctrl_cmd       o_cmd,
    output logic                     busy
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ACCESS = 7'b0000010,
        S_LOAD0  = 7'b0000100,
        S_LOADN  = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_operation != lge_pkg::OP_ADVANCE) begin
                        n_state = S_ACCESS;
                    end else if (i_status.grid_empty) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_LOAD0;
                    end
                end
            end
            S_ACCESS: n_state = S_IDLE;
            S_LOAD0:  n_state = S_LOADN;
            S_LOADN:  n_state = S_SCAN;
            S_SCAN: begin
                if (i_status.last_pos) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = i_status.last_row ? S_FINISH : S_LOADN;
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // decode commands
    assign o_cmd.capture   = (r_state == S_IDLE) && start;
    assign o_cmd.access    = (r_state == S_ACCESS);
    assign o_cmd.load0     = (r_state == S_LOAD0);
    assign o_cmd.loadn     = (r_state == S_LOADN);
    assign o_cmd.scan_step = (r_state == S_SCAN);
    assign o_cmd.row_write = (r_state == S_WRITE);
    assign o_cmd.finish    = (r_state == S_FINISH);

    assign busy = (r_state != S_IDLE);

    // checks
    `LGE_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted item did not raise busy")
    `LGE_ASSERT(a_scan_holds, i_clk, i_rst_n, (r_state == S_SCAN && !i_status.last_pos) |=> (r_state == S_SCAN), "scan left early")
    `LGE_ASSERT(a_next_line, i_clk, i_rst_n, (r_state == S_WRITE && !i_status.last_row) |=> (r_state == S_LOADN), "line step did not load next line")

endmodule

>>> tb/life_grid_generation_engine_core_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Life grid engine checker
// Follows configuration writes and accepted items, keeps its own copy of the
// grid, the sizes and the generation count, and compares each result strobe
// field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module life_grid_generation_engine_core_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lge_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lge_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [lge_pkg::OP_W-1:0]       i_operation,
    input  logic [lge_pkg::COORD_W-1:0]    i_line,
    input  logic [lge_pkg::COORD_W-1:0]    i_position,
    input  logic                           i_cell_value,
    input  logic                           i_result_strobe,
    input  logic                           i_read_value,
    input  logic                           i_out_of_range,
    input  logic [lge_pkg::GEN_W-1:0]      i_generation_count,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_advances
);
    import lge_pkg::*;

    typedef struct packed {
        logic             read_value;
        logic             out_of_range;
        logic [GEN_W-1:0] generation;
    } t_cell_result;

    bit                  life [0:MAX_LINES_DEF-1][0:MAX_CELLS_PER_LINE_DEF-1];
    logic [CFG_DATA_W-1:0] lines_reg;
    logic [CFG_DATA_W-1:0] cells_reg;
    logic [GEN_W-1:0]      gen_count;
    t_cell_result          owed_results [$];

    assign o_pending = owed_results.size();

    // clamp a size register to the grid bound
    function automatic int clamp_size(input logic [CFG_DATA_W-1:0] v, input int bound);
        return (int'(v) > bound) ? bound : int'(v);
    endfunction

    // compute the next generation from a snapshot of the current one
    task automatic step_generation();
        bit prior [0:MAX_LINES_DEF-1][0:MAX_CELLS_PER_LINE_DEF-1];
        int nl;
        int nc;
        int n;
        prior = life;
        nl = clamp_size(lines_reg, MAX_LINES_DEF);
        nc = clamp_size(cells_reg, MAX_CELLS_PER_LINE_DEF);
        for (int r = 0; r < nl; r++) begin
            for (int p = 0; p < nc; p++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        // cells beyond the used grid count as dead
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nl &&
                            p + dc >= 0 && p + dc < nc) begin
                            n += prior[r + dr][p + dc];
                        end
                    end
                end
                if (n == int'(BIRTH_COUNT)) begin
                    life[r][p] = 1'b1;
                end else if (n != int'(SURVIVE_COUNT)) begin
                    life[r][p] = 1'b0;
                end
            end
        end
        gen_count = gen_count + 1'b1;
        o_advances++;
    endtask

    // apply one item to the local grid and queue its result
    task automatic apply_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] ln,
                              input logic [COORD_W-1:0] ps, input logic v);
        t_cell_result res;
        bit           in_grid;
        res = '0;
        in_grid = (int'(ln) < clamp_size(lines_reg, MAX_LINES_DEF)) &&
                  (int'(ps) < clamp_size(cells_reg, MAX_CELLS_PER_LINE_DEF));
        case (op)
            OP_WRITE: begin
                if (!in_grid) res.out_of_range = 1'b1;
                else life[ln][ps] = v;
            end
            OP_READ: begin
                if (!in_grid) res.out_of_range = 1'b1;
                else res.read_value = life[ln][ps];
            end
            OP_ADVANCE: begin
                step_generation();
            end
            default: begin
            end
        endcase
        res.generation = gen_count;
        owed_results.push_back(res);
    endtask

    // compare one result with the oldest prediction
    task automatic compare_result();
        t_cell_result exp_res;
        if (owed_results.size() == 0) begin
            o_fail_count++;
            $display("%0t: result with nothing outstanding: read %0b oor %0b gen %0d",
                     $time, i_read_value, i_out_of_range, i_generation_count);
        end else begin
            exp_res = owed_results.pop_front();
            o_checked++;
            if (i_read_value !== exp_res.read_value) begin
                o_fail_count++;
                $display("%0t: read_value expected %0b actual %0b",
                         $time, exp_res.read_value, i_read_value);
            end
            if (i_out_of_range !== exp_res.out_of_range) begin
                o_fail_count++;
                $display("%0t: out_of_range expected %0b actual %0b",
                         $time, exp_res.out_of_range, i_out_of_range);
            end
            if (i_generation_count !== exp_res.generation) begin
                o_fail_count++;
                $display("%0t: generation_count expected %0d actual %0d",
                         $time, exp_res.generation, i_generation_count);
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_advances   = 0;
    end

    // sample both channels and the register port on each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            life = '{default: '{default: 1'b0}};
            lines_reg = LINES_IN_USE_RST;
            cells_reg = CELLS_PER_LINE_RST;
            gen_count = '0;
            owed_results.delete();
        end else begin
            if (i_result_strobe === 1'b1) compare_result();
            if (i_cfg_wr_en === 1'b1) begin
                case (i_cfg_index)
                    CFG_LINES_IN_USE:   lines_reg = i_cfg_wdata;
                    CFG_CELLS_PER_LINE: cells_reg = i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                apply_item(i_operation, i_line, i_position, i_cell_value);
            end
        end
    end

endmodule

>>> tb/life_grid_generation_engine_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Life grid engine testbench
// Drives directed cell writes, reads and advances at the reset grid size,
// then random items over a series of grid sizes from empty to saturated,
// with random gaps between items in most phases. A checker beside the block predicts and
// compares every result.
// ---------------------------------------------------------------------------
module life_grid_generation_engine_core_test;
    import lge_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
    localparam int              SETTLE     = 8;
    localparam int              CYCLE_CAP  = 2_500_000;
    localparam int              NUM_SIZES  = 10;
    localparam int              PHASE_ITEMS = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       operation;
    logic [COORD_W-1:0]    line;
    logic [COORD_W-1:0]    position;
    logic                  cell_value;
    logic                  result_strobe;
    logic                  read_value;
    logic                  out_of_range;
    logic [GEN_W-1:0]      generation_count;

    int fail_count;
    int pending;
    int checked;
    int advances;
    int items_sent;
    int cycle_count;

    // grid sizes per phase: empty, thin, tiny and saturated
    logic [CFG_DATA_W-1:0] size_lines [NUM_SIZES] = '{7'd0, 7'd5, 7'd1, 7'd3, 7'd6,
                                                      7'd127, 7'd2, 7'd64, 7'd8, 7'd100};
    logic [CFG_DATA_W-1:0] size_cells [NUM_SIZES] = '{7'd5, 7'd0, 7'd1, 7'd3, 7'd8,
                                                      7'd127, 7'd64, 7'd2, 7'd10, 7'd7};

    life_grid_generation_engine_core dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_index        (cfg_index),
        .i_cfg_wdata        (cfg_wdata),
        .start              (start),
        .busy               (busy),
        .i_operation        (operation),
        .i_line             (line),
        .i_position         (position),
        .i_cell_value       (cell_value),
        .o_result_strobe    (result_strobe),
        .o_read_value       (read_value),
        .o_out_of_range     (out_of_range),
        .o_generation_count (generation_count)
    );

    life_grid_generation_engine_core_checker checker_inst (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_index        (cfg_index),
        .i_cfg_wdata        (cfg_wdata),
        .i_start            (start),
        .i_busy             (busy),
        .i_operation        (operation),
        .i_line             (line),
        .i_position         (position),
        .i_cell_value       (cell_value),
        .i_result_strobe    (result_strobe),
        .i_read_value       (read_value),
        .i_out_of_range     (out_of_range),
        .i_generation_count (generation_count),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked),
        .o_advances         (advances)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // abandon the run at the cycle cap
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("life_grid_generation_engine_core_test: done, errors");
        $finish;
    end

    // hold an item on the port until the block takes it; returns at a falling edge
    task automatic issue(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] ln,
                         input logic [COORD_W-1:0] ps, input logic v);
        start      <= 1'b1;
        operation  <= op;
        line       <= ln;
        position   <= ps;
        cell_value <= v;
        do @(posedge clk); while (busy !== 1'b0);
        items_sent++;
        @(negedge clk);
    endtask

    // drop start for the requested idle length with noise on the fields
    task automatic idle_for(input int n);
        for (int k = 0; k < n; k++) begin
            if (k == 0) start <= 1'b0;
            operation  <= OP_W'($urandom_range(0, 3));
            line       <= COORD_W'($urandom);
            position   <= COORD_W'($urandom);
            cell_value <= 1'($urandom);
            @(negedge clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    // one random item: mostly in-grid writes and reads, some advances, some noise
    task automatic random_item(input int nl, input int nc);
        int                 roll;
        int                 advance_pct;
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] ln;
        logic [COORD_W-1:0] ps;
        logic               v;
        roll = $urandom_range(0, 99);
        advance_pct = (nl > 16) ? 4 : 18;
        ln = COORD_W'($urandom);
        ps = COORD_W'($urandom);
        v  = 1'($urandom);
        if (roll < advance_pct) begin
            op = OP_ADVANCE;
        end else if (roll < advance_pct + 10) begin
            // unused code or a coordinate anywhere in the field range
            op = $urandom_range(0, 1) ? OP_UNUSED : ($urandom_range(0, 1) ? OP_WRITE : OP_READ);
        end else begin
            op = (roll < 62) ? OP_WRITE : OP_READ;
            if (nl > 0 && nc > 0) begin
                ln = COORD_W'($urandom_range(0, nl - 1));
                ps = COORD_W'($urandom_range(0, nc - 1));
            end
        end
        issue(op, ln, ps, v);
    endtask

    initial begin
        int  nl;
        int  nc;
        bit  use_gaps;
        items_sent = 0;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_LINES_IN_USE;
        cfg_wdata  = '0;
        start      = 1'b0;
        operation  = OP_WRITE;
        line       = '0;
        position   = '0;
        cell_value = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: blinker mid-grid, block in the corner, lone far-corner cell
        issue(OP_WRITE, 6'd10, 6'd20, 1'b1);
        issue(OP_WRITE, 6'd10, 6'd21, 1'b1);
        issue(OP_WRITE, 6'd10, 6'd22, 1'b1);
        idle_for(2);
        issue(OP_WRITE, 6'd0, 6'd0, 1'b1);
        issue(OP_WRITE, 6'd0, 6'd1, 1'b1);
        issue(OP_WRITE, 6'd1, 6'd0, 1'b1);
        issue(OP_WRITE, 6'd1, 6'd1, 1'b1);
        issue(OP_WRITE, 6'd49, 6'd59, 1'b1);
        // out of range on each axis and at the field limits
        issue(OP_WRITE, 6'd63, 6'd63, 1'b1);
        issue(OP_READ, 6'd50, 6'd0, 1'b0);
        issue(OP_READ, 6'd0, 6'd60, 1'b0);
        issue(OP_UNUSED, 6'd63, 6'd63, 1'b1);
        issue(OP_READ, 6'd49, 6'd59, 1'b0);
        issue(OP_ADVANCE, 6'd0, 6'd0, 1'b0);
        issue(OP_READ, 6'd9, 6'd21, 1'b0);
        issue(OP_READ, 6'd10, 6'd20, 1'b0);
        issue(OP_READ, 6'd49, 6'd59, 1'b0);
        issue(OP_READ, 6'd0, 6'd0, 1'b0);
        idle_for(40);
        issue(OP_WRITE, 6'd10, 6'd21, 1'b0);
        issue(OP_ADVANCE, 6'd63, 6'd63, 1'b1);
        issue(OP_READ, 6'd11, 6'd21, 1'b0);
        issue(OP_WRITE, 6'd0, 6'd0, 1'b0);
        issue(OP_READ, 6'd0, 6'd0, 1'b0);
        drain();

        // random phases over the grid sizes
        for (int ph = 0; ph < NUM_SIZES; ph++) begin
            write_reg(CFG_LINES_IN_USE, size_lines[ph]);
            write_reg(CFG_CELLS_PER_LINE, size_cells[ph]);
            nl = (size_lines[ph] > MAX_LINES_DEF) ? MAX_LINES_DEF : int'(size_lines[ph]);
            nc = (size_cells[ph] > MAX_CELLS_PER_LINE_DEF) ?
                 MAX_CELLS_PER_LINE_DEF : int'(size_cells[ph]);
            use_gaps = (ph % 3) != 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_item(nl, nc);
                // hold off once mid-phase until the block has caught up
                if (ph == 4 && k == PHASE_ITEMS / 2) drain();
                else if (use_gaps) idle_for(pick_gap());
            end
            drain();
        end

        $display("Sent %0d items over %0d grid sizes plus the reset size; %0d advances.",
                 items_sent, NUM_SIZES, advances);
        $display("Checked %0d results, %0d mismatches, %0d left outstanding.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("life_grid_generation_engine_core_test: done, clean");
        end else begin
            $display("life_grid_generation_engine_core_test: done, errors");
        end
        $finish;
    end

endmodule
